>>> hdl/pip_pkg.sv
package pip_pkg;

    localparam int COORD_W   = 16;
    localparam int RAY_W     = 16;
    localparam int COUNT_W   = 11;
    localparam int MAX_EDGES = 1024;
    // Counter stops at the edge limit, or at the largest 11-bit value below it
    localparam int COUNT_CAP = (MAX_EDGES < 2047) ? MAX_EDGES : 2047;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] edge_start_x;
        logic signed [COORD_W-1:0] edge_start_y;
        logic signed [COORD_W-1:0] edge_end_x;
        logic signed [COORD_W-1:0] edge_end_y;
        logic                      last_edge;
    } pip_in_t;

    typedef struct packed {
        logic               inside_res;
        logic [COUNT_W-1:0] crossing_count;
    } pip_out_t;

    // Classified edge handed from the front to the back
    typedef struct packed {
        logic hit;
        logic last;
    } pip_cls_t;

    typedef enum logic [1:0] {
        SGN_ZERO,
        SGN_POS,
        SGN_NEG
    } sgn_t;

endpackage

>>> hdl/pip_front.sv
module pip_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  pip_pkg::pip_in_t         s_data,
    input  logic [pip_pkg::RAY_W-1:0] ray_length,
    output logic                     q_push,
    output pip_pkg::pip_cls_t        q_data,
    input  logic                     q_full
);
    import pip_pkg::*;

    // Input side: differences, the three products, ray-side flags
    logic signed [COORD_W-1:0] px, py, sx, sy, ex, ey;
    logic signed [17:0]        rx;
    logic signed [16:0]        dy_es, dx_pe, dx_es, dy_pe;
    logic signed [18:0]        dx_re;
    logic signed [33:0]        m3a_c, m3b_c;
    logic signed [35:0]        m4a_c;
    sgn_t                      o1_c, o2_c;
    logic                      b1_c, b2_c, b3_c, b4_c;
    logic                      in_x_se, in_y_se, rx_in_se;

    // Stage register
    logic                      v1_reg, v1_next;
    logic signed [33:0]        m3a_reg, m3b_reg;
    logic signed [35:0]        m4a_reg;
    sgn_t                      o1_reg, o2_reg;
    logic                      b1_reg, b2_reg, b3_reg, b4_reg, last_reg;

    // Output side
    logic signed [34:0]        d3;
    logic signed [36:0]        d4;
    sgn_t                      o3, o4;
    logic                      load;

    always_comb begin
        px = s_data.point_x;
        py = s_data.point_y;
        sx = s_data.edge_start_x;
        sy = s_data.edge_start_y;
        ex = s_data.edge_end_x;
        ey = s_data.edge_end_y;
        rx = 18'(px) + signed'({2'b00, ray_length});

        dy_es = 17'(ey) - 17'(sy);
        dx_pe = 17'(px) - 17'(ex);
        dx_es = 17'(ex) - 17'(sx);
        dy_pe = 17'(py) - 17'(ey);
        dx_re = 19'(rx) - 19'(ex);

        m3a_c = 34'(dy_es) * 34'(dx_pe);
        m3b_c = 34'(dx_es) * 34'(dy_pe);
        m4a_c = 36'(dy_es) * 36'(dx_re);

        // The ray is horizontal, so its side tests reduce to y compares
        if (ray_length == '0 || sy == py) begin
            o1_c = SGN_ZERO;
        end else if (sy > py) begin
            o1_c = SGN_NEG;
        end else begin
            o1_c = SGN_POS;
        end
        if (ray_length == '0 || ey == py) begin
            o2_c = SGN_ZERO;
        end else if (ey > py) begin
            o2_c = SGN_NEG;
        end else begin
            o2_c = SGN_POS;
        end

        // Endpoint on the ray; an endpoint equal to the point itself never counts here
        b1_c = (sx != px || sy != py) && sy == py && sx >= px && 18'(sx) <= rx;
        b2_c = (ex != px || ey != py) && ey == py && ex >= px && 18'(ex) <= rx;

        in_x_se  = (px >= sx && px <= ex) || (px >= ex && px <= sx);
        in_y_se  = (py >= sy && py <= ey) || (py >= ey && py <= sy);
        rx_in_se = (rx >= 18'(sx) && rx <= 18'(ex)) || (rx >= 18'(ex) && rx <= 18'(sx));

        b3_c = (sx != px || sy != py) && in_x_se && in_y_se;
        b4_c = (18'(sx) != rx || sy != py) && rx_in_se && in_y_se;
    end

    assign s_ready = !v1_reg || !q_full;
    assign load    = s_valid && s_ready;
    assign q_push  = v1_reg && !q_full;

    always_comb begin
        v1_next = s_ready ? s_valid : v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m3a_reg  <= m3a_c;
            m3b_reg  <= m3b_c;
            m4a_reg  <= m4a_c;
            o1_reg   <= o1_c;
            o2_reg   <= o2_c;
            b1_reg   <= b1_c;
            b2_reg   <= b2_c;
            b3_reg   <= b3_c;
            b4_reg   <= b4_c;
            last_reg <= s_data.last_edge;
        end
    end

    always_comb begin
        d3 = 35'(m3a_reg) - 35'(m3b_reg);
        d4 = 37'(m4a_reg) - 37'(m3b_reg);
        if (d3 == '0) begin
            o3 = SGN_ZERO;
        end else if (d3[34]) begin
            o3 = SGN_NEG;
        end else begin
            o3 = SGN_POS;
        end
        if (d4 == '0) begin
            o4 = SGN_ZERO;
        end else if (d4[36]) begin
            o4 = SGN_NEG;
        end else begin
            o4 = SGN_POS;
        end
        q_data.hit = (o1_reg != o2_reg && o3 != o4) || b1_reg || b2_reg ||
                     (o3 == SGN_ZERO && b3_reg) || (o4 == SGN_ZERO && b4_reg);
        q_data.last = last_reg;
    end

endmodule

>>> hdl/pip_queue.sv
module pip_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pip_pkg::pip_cls_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output pip_pkg::pip_cls_t pop_data
);
    import pip_pkg::*;

    pip_cls_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/pip_back.sv
module pip_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  pip_pkg::pip_cls_t q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output pip_pkg::pip_out_t m_data
);
    import pip_pkg::*;

    logic [COUNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic               m_valid_reg, m_valid_next;
    pip_out_t           m_data_reg;
    logic               slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    // A last word needs room in the output register; other words drain freely
    assign q_pop     = q_valid && (!q_data.last || slot_free);

    always_comb begin
        cnt_upd = cnt_reg;
        if (q_data.hit && cnt_reg < COUNT_W'(COUNT_CAP)) begin
            cnt_upd = cnt_reg + 1'b1;
        end
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            if (q_data.last) begin
                cnt_next     = '0;
                m_valid_next = 1'b1;
            end else begin
                cnt_next = cnt_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_data.last) begin
            m_data_reg.inside_res     <= cnt_upd[0];
            m_data_reg.crossing_count <= cnt_upd;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= COUNT_W'(COUNT_CAP))
        else $error("hit counter above cap");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_data.last |=> cnt_reg == '0 && m_valid_reg)
        else $error("counter not cleared or word lost after last edge");

    a_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.inside_res == m_data_reg.crossing_count[0])
        else $error("inside flag disagrees with count parity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(q_pop && q_data.last))
        else $error("pending result overwritten");

endmodule

>>> hdl/point_in_polygon_ray_cast.sv
// Streams polygon edges, one per cycle while s_ready is high, each word carrying
// the query point and one edge; a horizontal ray from the point to x plus
// ray_length is tested against every edge and hits are counted (saturating at
// the edge limit). The word flagged last_edge yields one result, the count and
// its parity as the inside flag, and starts a fresh polygon. Sustained rate is
// one edge per clock while results are taken: the front computes three products
// (two 17x17, one 17x19) in one register stage, then pushes a hit/last flag
// into a four-entry queue that the counter drains one entry per clock, a last
// entry only while the output register has room. ray_length is written through
// the cfg port, always ready, and must only be changed while no polygon is in flight.
module point_in_polygon_ray_cast (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pip_pkg::RAY_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pip_pkg::pip_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output pip_pkg::pip_out_t          m_data
);
    import pip_pkg::*;

    localparam logic [RAY_W-1:0] RAY_RESET = RAY_W'(32767);

    logic [RAY_W-1:0] ray_len_reg;
    logic             q_push, q_full, q_pop, q_valid;
    pip_cls_t         q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_len_reg <= RAY_RESET;
        end else if (cfg_valid) begin
            ray_len_reg <= cfg_data;
        end
    end

    pip_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .ray_length (ray_len_reg),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full)
    );

    pip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_rdata)
    );

    pip_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
